>>> rtl/payload_signature_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the payload signature classifier
// Implication checks, same cycle and next cycle, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PAYLOAD_SIGNATURE_CLASSIFIER_UNIT_MACROS_SVH
`define PAYLOAD_SIGNATURE_CLASSIFIER_UNIT_MACROS_SVH

// ante true implies cons true at the same edge
`define PSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psc: same-cycle check failed");

// ante true implies cons true at the following edge
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psc: next-cycle check failed");

`endif

>>> rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types and signature constants for the payload signature classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Byte counter width; the count saturates at its maximum
  localparam int LenBits = 16;
  localparam logic [LenBits-1:0] CntMax = {LenBits{1'b1}};

  localparam int HeaderDepth = 16;

  typedef logic [7:0]         data_t;
  typedef logic [LenBits-1:0] len_t;

  // Length limits
  localparam int MinLen      = 10;
  localparam int SyncLen     = 16;
  localparam int NetMinLen   = 50;
  localparam int SyncDataLen = 4;
  localparam int MarkerBase  = 16;
  localparam int MarkerEnd   = 20;
  localparam int LenPad      = 8;

  // Signature words
  localparam logic [31:0] LoginHead  = 32'h000b_0000;
  localparam logic [15:0] LoginType  = 16'h0008;
  localparam logic [15:0] SyncHead   = 16'h001c;
  localparam logic [31:0] SyncWordA  = 32'h0000_0500;
  localparam logic [31:0] SyncWordB  = 32'h0001_0000;
  localparam logic [15:0] NetHead    = 16'h0018;
  localparam logic [31:0] MarkerA    = 32'h0001_0000;
  localparam logic [31:0] MarkerB    = 32'h0000_0001;

endpackage

>>> rtl/psc_byte_if.sv
// ----------------------------------------------------------------------------
// psc_byte_if
// Payload byte channel: valid/ready with one byte and a last-byte flag.
// ----------------------------------------------------------------------------
interface psc_byte_if import psc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/psc_verdict_if.sv
// ----------------------------------------------------------------------------
// psc_verdict_if
// Verdict channel: valid/ready with a one-bit match result.
// ----------------------------------------------------------------------------
interface psc_verdict_if;
  logic valid;
  logic ready;
  logic match;

  modport source (output valid, output match, input ready);
  modport sink   (input valid, input match, output ready);
endinterface

>>> rtl/payload_signature_classifier_unit.sv
// ----------------------------------------------------------------------------
// payload_signature_classifier_unit
// Classifies a UDP payload against login, sync and net-sync signatures.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one payload byte per transfer, last_byte set on the final
//          byte of the packet.
//   out_ch gives one match bit per packet, after its final byte.
// Throughput: one byte per cycle, packets back to back, except while a stall
//   below holds in_ch. Verdict path: the final byte waits in the input
//   register, then the evaluation logic updates the packet captures and
//   loads the verdict register.
// Stall: a waiting verdict holds in the output register; bytes of the next
//   packet keep flowing. Only when a second final byte reaches the
//   evaluation stage while the verdict is still untaken does in_ch.ready
//   drop, until out_ch is served.
// Reset: rst (synchronous) empties both stages and clears the byte count,
//   header captures, tail bytes and marker capture. These are cleared again
//   after every final byte.
// ----------------------------------------------------------------------------
`include "payload_signature_classifier_unit_macros.svh"

module payload_signature_classifier_unit import psc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  psc_byte_if.sink      in_ch,
  psc_verdict_if.source out_ch
);

  // Input register
  logic  s1_valid;
  data_t s1_byte;
  logic  s1_last;

  // Packet state
  len_t        byte_count;
  data_t       hdr [HeaderDepth];
  logic [15:0] tail_pair;
  logic [15:0] marker_offset;
  logic [31:0] marker_word;

  // Output register
  logic out_valid;
  logic out_match;

  logic s1_adv;
  logic step;
  logic in_take;

  assign s1_adv  = !s1_last || !out_valid || out_ch.ready;
  assign step    = s1_valid && s1_adv;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_take = in_ch.valid && in_ch.ready;

  // Packet state after the byte in the input register
  logic        cnt_live;
  len_t        len_upd;
  data_t       hdr_upd [HeaderDepth];
  logic [15:0] tail_upd;
  logic [15:0] off_upd;
  logic [31:0] marker_upd;
  logic [17:0] mk_diff;
  logic        mk_hit;

  assign cnt_live = (byte_count != CntMax);
  assign len_upd  = cnt_live ? byte_count + len_t'(1) : byte_count;
  assign tail_upd = {tail_pair[7:0], s1_byte};

  always_comb begin
    for (int i = 0; i < HeaderDepth; i++) begin
      hdr_upd[i] = (cnt_live && byte_count == len_t'(i)) ? s1_byte : hdr[i];
    end
  end

  always_comb begin
    off_upd = marker_offset;
    if (cnt_live && byte_count == len_t'(14)) begin
      off_upd = {s1_byte, marker_offset[7:0]};
    end else if (cnt_live && byte_count == len_t'(15)) begin
      off_upd = {marker_offset[15:8], s1_byte};
    end
  end

  // Marker lands at offset 16 + V; the offset is final by byte 16
  assign mk_diff = 18'(byte_count) - (18'(MarkerBase) + 18'(marker_offset));
  assign mk_hit  = cnt_live && (byte_count >= len_t'(MarkerBase)) && !mk_diff[17]
                   && (mk_diff[16:2] == '0);

  always_comb begin
    marker_upd = marker_word;
    if (mk_hit) begin
      case (mk_diff[1:0])
        2'd0:    marker_upd[31:24] = s1_byte;
        2'd1:    marker_upd[23:16] = s1_byte;
        2'd2:    marker_upd[15:8]  = s1_byte;
        default: marker_upd[7:0]   = s1_byte;
      endcase
    end
  end

  // Verdict on the updated captures
  logic [15:0] d_word;
  logic [17:0] len_w;
  logic [17:0] d_span;
  logic        tail_zero;
  logic        login_hit, login_excl, login_ok;
  logic        sync_hit, sync_excl, sync_ok;
  logic        net_hit, net_excl, net_ok;
  logic        net_res, sync_res, verdict;

  assign d_word    = {hdr_upd[4], hdr_upd[5]};
  assign len_w     = 18'(len_upd);
  assign d_span    = {1'b0, d_word, 1'b0} + 18'(LenPad);
  assign tail_zero = (tail_upd == '0);

  assign login_hit  = (len_upd > len_t'(MinLen))
                      && ({hdr_upd[0], hdr_upd[1], hdr_upd[2], hdr_upd[3]} == LoginHead);
  assign login_excl = (d_word == '0) || (d_span != len_w);
  assign login_ok   = ({hdr_upd[6], hdr_upd[7]} == LoginType) && tail_zero;

  assign sync_hit  = (len_upd == len_t'(SyncLen)) && ({hdr_upd[0], hdr_upd[1]} == SyncHead)
                     && ({hdr_upd[2], hdr_upd[3]} != '0);
  assign sync_excl = (d_word != 16'(SyncDataLen));
  assign sync_ok   = ({hdr_upd[6], hdr_upd[7], hdr_upd[8], hdr_upd[9]} == SyncWordA)
                     && ({hdr_upd[10], hdr_upd[11], hdr_upd[12], hdr_upd[13]} == SyncWordB)
                     && tail_zero;

  assign net_hit  = (len_upd > len_t'(NetMinLen)) && ({hdr_upd[0], hdr_upd[1]} == NetHead)
                    && ({hdr_upd[2], hdr_upd[3]} != '0);
  assign net_excl = (d_word == '0) || (d_span > len_w);
  assign net_ok   = ({hdr_upd[8], hdr_upd[9]} == {hdr_upd[12], hdr_upd[13]})
                    && ((18'(MarkerEnd) + 18'(off_upd)) < len_w)
                    && ((marker_upd == MarkerA) || (marker_upd == MarkerB))
                    && tail_zero;

  // Checked in order; an exclusion ends the search, a miss falls through
  assign net_res  = net_hit && !net_excl && net_ok;
  assign sync_res = sync_hit ? (!sync_excl && (sync_ok || net_res)) : net_res;
  assign verdict  = login_hit ? (!login_excl && (login_ok || sync_res)) : sync_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      byte_count    <= '0;
      tail_pair     <= '0;
      marker_offset <= '0;
      marker_word   <= '0;
      for (int i = 0; i < HeaderDepth; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (in_take) begin
        s1_byte <= in_ch.data_byte;
        s1_last <= in_ch.last_byte;
      end
      if (step && s1_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (s1_last) begin
          out_match     <= verdict;
          byte_count    <= '0;
          tail_pair     <= '0;
          marker_offset <= '0;
          marker_word   <= '0;
          for (int i = 0; i < HeaderDepth; i++) begin
            hdr[i] <= '0;
          end
        end else begin
          byte_count    <= len_upd;
          tail_pair     <= tail_upd;
          marker_offset <= off_upd;
          marker_word   <= marker_upd;
          for (int i = 0; i < HeaderDepth; i++) begin
            hdr[i] <= hdr_upd[i];
          end
        end
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.match = out_match;

  `PSC_ASSERT_NEXT(a_last_clears, clk, rst, step && s1_last, byte_count == '0)
  `PSC_ASSERT_NEXT(a_last_gives_verdict, clk, rst, step && s1_last, out_valid)
  `PSC_ASSERT_NEXT(a_count_saturates, clk, rst,
                   step && !s1_last && byte_count == CntMax, byte_count == CntMax)
  `PSC_ASSERT_SAME(a_stall_blocks_input, clk, rst, s1_valid && !s1_adv, !in_ch.ready)

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the payload signature classifier. Packets are built as login,
// sync and net-sync frames, as plain noise or as frames with a corrupted
// byte, streamed over the byte channel with random gaps. Each verdict is
// scored against its row's want or an in-bench copy of the classifier state.
// ----------------------------------------------------------------------------
module tb;
  import psc_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 5;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 10;
  localparam int SinkHold    = 150;
  localparam int RandBytes   = 1000;
  localparam int RandFrames  = 24;
  localparam int CalmBytes   = 300;
  localparam int FromModel   = -1;
  localparam int NoPoke      = -1;

  typedef enum logic [2:0] {PK_NOISE, PK_LOGIN, PK_SYNC, PK_NET} pkt_kind_t;

  // One frame recipe: signature fields, an optional corrupted byte and,
  // where it is obvious, the verdict to expect.
  typedef struct packed {
    pkt_kind_t   kind;
    int unsigned len;
    int unsigned dval;
    int unsigned voff;
    logic [31:0] mark;
    int          poke_at;
    logic [7:0]  poke_val;
    int          want;
  } row_t;

  localparam int NumSteps = 22;
  localparam row_t Steps [NumSteps] = '{
    '{PK_NOISE,     1,      0,      0, 32'h0,   0,     8'hff, 0},
    '{PK_NOISE,    10,      0,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_LOGIN,    10,      1,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_LOGIN,    12,      2,      0, 32'h0,   NoPoke, 8'h0, 1},
    '{PK_LOGIN,    12,      0,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_LOGIN,    13,      2,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_LOGIN,    12,      2,      0, 32'h0,   11,    8'h01, 0},
    '{PK_LOGIN,    20,  65535,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_LOGIN,    68,     30,      0, 32'h0,   NoPoke, 8'h0, 1},
    '{PK_SYNC,     16,      4,      0, 32'h0,   NoPoke, 8'h0, 1},
    '{PK_SYNC,     16,      5,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_SYNC,     16,      4,      0, 32'h0,   9,     8'hff, 0},
    '{PK_SYNC,     17,      4,      0, 32'h0,   NoPoke, 8'h0, 0},
    '{PK_SYNC,     16,      4,      0, 32'h0,   2,     8'h00, FromModel},
    '{PK_NET,      51,     21,      0, MarkerA, NoPoke, 8'h0, FromModel},
    '{PK_NET,      60,     20,     39, MarkerA, NoPoke, 8'h0, FromModel},
    '{PK_NET,      60,     10,      0, MarkerB, NoPoke, 8'h0, FromModel},
    '{PK_NET,      60,     10,  65535, MarkerA, NoPoke, 8'h0, FromModel},
    '{PK_NET,      60,      0,      0, MarkerA, NoPoke, 8'h0, 0},
    '{PK_NET,      60,     30,      0, MarkerA, NoPoke, 8'h0, 0},
    '{PK_NET,      50,     10,      0, MarkerA, NoPoke, 8'h0, 0},
    '{PK_NET,      60,     10,      5, MarkerA, 9,     8'h5a, FromModel}
  };

  logic clk = 1'b0;
  logic rst;

  psc_byte_if    in_ch ();
  psc_verdict_if out_ch ();

  payload_signature_classifier_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Classifier state as seen by the bench
  // --------------------------------------------------------------------------
  len_t        pk_count;
  logic [7:0]  pk_head [HeaderDepth];
  logic [15:0] pk_tail;
  logic [15:0] pk_moff;
  logic [31:0] pk_mark;

  bit verdict_q [$];
  int typed_q [$];
  int mismatches = 0;
  int cycles = 0;

  bit calm;
  bit hold_req;
  bit hold_done = 1'b0;
  logic [7:0] frame [$];

  function automatic void clear_packet();
    pk_count = '0;
    foreach (pk_head[i]) pk_head[i] = '0;
    pk_tail = '0;
    pk_moff = '0;
    pk_mark = '0;
  endfunction

  function automatic logic [15:0] head16(int unsigned p);
    return {pk_head[p % HeaderDepth], pk_head[(p + 1) % HeaderDepth]};
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    int unsigned pos;
    int unsigned base;
    int unsigned k;
    pos  = pk_count;
    base = MarkerBase + pk_moff;
    if (pos < CntMax) begin
      if (pos < HeaderDepth) pk_head[pos] = b;
      if (pos == 14) pk_moff[15:8] = b;
      else if (pos == 15) pk_moff[7:0] = b;
      if (pos >= base && pos - base < 4) begin
        k = pos - base;
        pk_mark[(3 - k) * 8 +: 8] = b;
      end
      pk_count = len_t'(pos + 1);
    end
    pk_tail = {pk_tail[7:0], b};
  endfunction

  function automatic bit judge_packet(int unsigned len);
    int unsigned d;
    int unsigned span;
    bit tail_zero;
    d         = head16(4);
    span      = d * 2 + LenPad;
    tail_zero = (pk_tail == 16'h0);
    if (len <= MinLen) return 1'b0;
    if ({head16(0), head16(2)} == LoginHead) begin
      if (d == 0 || span != len) return 1'b0;
      if (head16(6) == LoginType && tail_zero) return 1'b1;
    end
    if (len == SyncLen && head16(0) == SyncHead && head16(2) != 16'h0) begin
      if (d != SyncDataLen) return 1'b0;
      if ({head16(6), head16(8)} == SyncWordA && {head16(10), head16(12)} == SyncWordB
          && tail_zero) return 1'b1;
    end
    if (len > NetMinLen && head16(0) == NetHead && head16(2) != 16'h0) begin
      if (d == 0 || span > len) return 1'b0;
      if (head16(8) == head16(12) && MarkerEnd + int'(pk_moff) < len
          && (pk_mark == MarkerA || pk_mark == MarkerB) && tail_zero) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic got, int want);
    $display("MISMATCH %s: got %b want %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: verdicts are scored before the byte of the same edge is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    bit verdict;
    int typed;
    if (rst) begin
      clear_packet();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with nothing pending", out_ch.match, FromModel);
        end else begin
          verdict = verdict_q.pop_front();
          if (out_ch.match !== verdict) report_mismatch("match", out_ch.match, verdict);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_byte(in_ch.data_byte);
        if (in_ch.last_byte) begin
          verdict = judge_packet(pk_count);
          clear_packet();
          typed = typed_q.pop_front();
          verdict_q.push_back(typed == FromModel ? verdict : typed[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Frame construction
  // --------------------------------------------------------------------------
  function automatic void put8(int unsigned p, logic [7:0] v);
    if (p < frame.size()) frame[p] = v;
  endfunction

  function automatic void put16(int unsigned p, logic [15:0] v);
    put8(p, v[15:8]);
    put8(p + 1, v[7:0]);
  endfunction

  function automatic void put32(int unsigned p, logic [31:0] v);
    put16(p, v[31:16]);
    put16(p + 2, v[15:0]);
  endfunction

  function automatic void build_frame(row_t r);
    logic [15:0] w;
    frame.delete();
    repeat (r.len) frame.push_back(8'($urandom_range(0, 255)));
    case (r.kind)
      PK_LOGIN: begin
        put32(0, LoginHead);
        put16(4, r.dval[15:0]);
        put16(6, LoginType);
      end
      PK_SYNC: begin
        put16(0, SyncHead);
        put16(2, 16'($urandom_range(1, 65535)));
        put16(4, r.dval[15:0]);
        put32(6, SyncWordA);
        put32(10, SyncWordB);
      end
      PK_NET: begin
        w = 16'($urandom_range(0, 65535));
        put16(0, NetHead);
        put16(2, 16'($urandom_range(1, 65535)));
        put16(4, r.dval[15:0]);
        put16(8, w);
        put16(12, w);
        put16(14, r.voff[15:0]);
        put32(MarkerBase + r.voff, r.mark);
      end
      default: ;
    endcase
    if (r.kind != PK_NOISE && r.len >= 2) begin
      put8(r.len - 2, 8'h00);
      put8(r.len - 1, 8'h00);
    end
    if (r.poke_at != NoPoke) put8(r.poke_at, r.poke_val);
  endfunction

  // Mostly well-formed frames with random content; a quarter get a bad byte
  function automatic row_t random_row();
    row_t r;
    int unsigned pick;
    r.want     = FromModel;
    r.dval     = 0;
    r.voff     = 0;
    r.mark     = 32'h0;
    r.poke_val = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.kind = PK_NET;
      r.len  = $urandom_range(51, 90);
      r.dval = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(1, (r.len - LenPad) / 2);
      r.voff = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, r.len - 21);
      case ($urandom_range(0, 4))
        0, 1:    r.mark = MarkerA;
        2, 3:    r.mark = MarkerB;
        default: r.mark = $urandom;
      endcase
    end else if (pick < 55) begin
      r.kind = PK_LOGIN;
      r.dval = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
      r.len  = (r.dval == 0) ? $urandom_range(11, 30) : r.dval * 2 + LenPad;
      if ($urandom_range(0, 4) == 0) r.len = r.len + $urandom_range(0, 2) - 1;
    end else if (pick < 80) begin
      r.kind = PK_SYNC;
      r.len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : SyncLen;
      r.dval = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : SyncDataLen;
    end else begin
      r.kind = PK_NOISE;
      r.len  = $urandom_range(1, 40);
    end
    r.poke_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, r.len - 1)) : NoPoke;
    return r;
  endfunction

  // valid stays high across frames; it is only lowered for a gap
  task automatic send_frame(int want, bit gaps);
    typed_q.push_back(want);
    foreach (frame[i]) begin
      if (gaps && !calm && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= frame[i];
      in_ch.last_byte <= (i == frame.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Verdict receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (SinkHold) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    row_t r;
    int unsigned rnd_bytes;
    int unsigned rnd_frames;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    rnd_bytes       = 0;
    rnd_frames      = 0;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (Steps[i]) begin
      build_frame(Steps[i]);
      send_frame(Steps[i].want, frame.size() < 1000 && $urandom_range(0, 2) != 0);
    end

    // Back-to-back short frames while the receiver holds off fill the block
    hold_req = 1'b1;
    repeat (12) begin
      r = '{PK_NOISE, $urandom_range(1, 3), 0, 0, 32'h0, NoPoke, 8'h0, 0};
      build_frame(r);
      send_frame(r.want, 1'b0);
    end

    while (rnd_bytes < RandBytes || rnd_frames < RandFrames) begin
      if (rnd_bytes + CalmBytes >= RandBytes) calm = 1'b1;
      r = random_row();
      build_frame(r);
      send_frame(r.want, $urandom_range(0, 2) != 0);
      rnd_bytes += frame.size();
      rnd_frames++;
    end
    in_ch.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> payload_signature_classifier_unit.f
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_byte_if.sv
rtl/psc_verdict_if.sv
rtl/payload_signature_classifier_unit.sv
verif/tb.sv
